// ===== hw/rtl/upwc_pkg.sv =====
// ----------------------------------------------------------------------------
// upwc_pkg: shared types and constants of the user buffer page walk check
// opcodes, reason codes, sequencer states and entry bit positions
// ----------------------------------------------------------------------------
`default_nettype none

package upwc_pkg;

  // input item opcodes
  typedef enum logic [1:0] {
    OP_TABLE_WRITE = 2'd0,
    OP_CHECK_READ  = 2'd1,
    OP_CHECK_WRITE = 2'd2
  } opcode_e;

  // result reason codes
  typedef enum logic [2:0] {
    RSN_OK           = 3'd0,
    RSN_WRAP         = 3'd1,
    RSN_ABOVE_LIMIT  = 3'd2,
    RSN_L1_INVALID   = 3'd3,
    RSN_L0_INVALID   = 3'd4,
    RSN_NOT_USER     = 3'd5,
    RSN_NOT_WRITABLE = 3'd6,
    RSN_OUTSIDE      = 3'd7
  } reason_e;

  // walk sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_L1_REQ,
    ST_L1_CHK,
    ST_L0_CHK,
    ST_DONE
  } state_e;

  // widths of the fixed fields
  localparam int unsigned PpnW  = 22;
  localparam int unsigned VpnW  = 10;
  localparam int unsigned PageW = 20;
  localparam int unsigned IdxW  = 32;

  // highest allowed buffer end
  localparam logic [31:0] UserLimit = 32'h8000_0000;

  // page table entry bit positions
  localparam int unsigned PteBitV = 0;
  localparam int unsigned PteBitW = 2;
  localparam int unsigned PteBitU = 4;

endpackage

`default_nettype wire

// ===== hw/rtl/upwc_ram.sv =====
// ----------------------------------------------------------------------------
// upwc_ram: generic single port ram
// one write or read per cycle, read data registered
// ----------------------------------------------------------------------------
`default_nettype none

module upwc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/upwc_idx_unit.sv =====
// ----------------------------------------------------------------------------
// upwc_idx_unit: shared table index unit
// forms a store word index from a table ppn and a vpn, flags it when outside the store
// ----------------------------------------------------------------------------
`default_nettype none

module upwc_idx_unit #(
  parameter int unsigned StoreWords = 65536
) (
  input  wire logic [upwc_pkg::PpnW-1:0] ppn_i,
  input  wire logic [upwc_pkg::VpnW-1:0] vpn_i,
  output logic      [upwc_pkg::IdxW-1:0] idx_o,
  output logic                           outside_o
);

  localparam logic [upwc_pkg::IdxW-1:0] StoreWordsW = upwc_pkg::IdxW'(StoreWords);

  // index is ppn * 1024 + vpn, compared against the store size
  always_comb begin
    idx_o     = {ppn_i, vpn_i};
    outside_o = (idx_o >= StoreWordsW);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/upwc_walker.sv =====
// ----------------------------------------------------------------------------
// upwc_walker: page walk sequencer
// takes items, drives the table store and walks each spanned page up to the first failing page
// ----------------------------------------------------------------------------
`default_nettype none

module upwc_walker #(
  parameter int unsigned StoreWords = 65536,
  parameter int unsigned AddrW      = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [upwc_pkg::PpnW-1:0]     root_ppn_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [15:0]                   word_index_i,
  input  wire logic [31:0]                   word_data_i,
  input  wire logic [31:0]                   buf_address_i,
  input  wire logic [31:0]                   buf_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               access_ok_o,
  output logic [2:0]                         reason_o,
  output logic                               ram_we_o,
  output logic [AddrW-1:0]                   ram_addr_o,
  output logic [31:0]                        ram_wdata_o,
  input  wire logic [31:0]                   ram_rdata_i
);

  localparam logic [31:0] StoreWordsW = 32'(StoreWords);

  upwc_pkg::state_e  state_q, state_d;
  upwc_pkg::reason_e reason_q, reason_d;
  upwc_pkg::reason_e out_reason_q;
  logic              out_valid_q;

  logic [31:0]                 addr_q, len_q;
  logic                        need_w_q;
  logic [upwc_pkg::PageW-1:0]  va_pn_q, va_pn_d;
  logic [upwc_pkg::PageW-1:0]  last_pn_q, last_pn_d;

  logic [32:0]                 end_sum;
  logic                        end_wrap;
  logic                        end_over;
  logic                        page_left;
  logic                        out_free;

  logic [upwc_pkg::PpnW-1:0]   unit_ppn;
  logic [upwc_pkg::VpnW-1:0]   unit_vpn;
  logic [upwc_pkg::IdxW-1:0]   unit_idx;
  logic                        unit_outside;

  logic [31:0]                 widx_ext;
  logic                        is_check;

  // shared index and bound unit
  upwc_idx_unit #(
    .StoreWords(StoreWords)
  ) u_idx_unit (
    .ppn_i    (unit_ppn),
    .vpn_i    (unit_vpn),
    .idx_o    (unit_idx),
    .outside_o(unit_outside)
  );

  // unit operands: entry pointer and level-0 vpn in the level-1 check, root table and level-1 vpn otherwise
  always_comb begin
    if (state_q == upwc_pkg::ST_L1_CHK) begin
      unit_ppn = ram_rdata_i[31:10];
      unit_vpn = va_pn_q[upwc_pkg::VpnW-1:0];
    end else begin
      unit_ppn = root_ppn_i;
      unit_vpn = va_pn_q[upwc_pkg::PageW-1:upwc_pkg::VpnW];
    end
  end

  // buffer end, wrap and limit
  assign end_sum   = {1'b0, addr_q} + {1'b0, len_q};
  assign end_wrap  = end_sum[32];
  assign end_over  = (end_sum[31:0] > upwc_pkg::UserLimit);
  assign page_left = (va_pn_q < last_pn_q);
  assign out_free  = !out_valid_q || out_ready_i;

  assign widx_ext = {16'd0, word_index_i};
  assign is_check = (opcode_i == upwc_pkg::OP_CHECK_READ) ||
                    (opcode_i == upwc_pkg::OP_CHECK_WRITE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      upwc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = is_check ? upwc_pkg::ST_SETUP : upwc_pkg::ST_DONE;
        end
      end
      upwc_pkg::ST_SETUP: begin
        state_d = (end_wrap || end_over) ? upwc_pkg::ST_DONE : upwc_pkg::ST_L1_REQ;
      end
      upwc_pkg::ST_L1_REQ: begin
        state_d = (!page_left || unit_outside) ? upwc_pkg::ST_DONE
                                               : upwc_pkg::ST_L1_CHK;
      end
      upwc_pkg::ST_L1_CHK: begin
        state_d = (!ram_rdata_i[upwc_pkg::PteBitV] || unit_outside)
                  ? upwc_pkg::ST_DONE : upwc_pkg::ST_L0_CHK;
      end
      upwc_pkg::ST_L0_CHK: begin
        state_d = (reason_d != upwc_pkg::RSN_OK) ? upwc_pkg::ST_DONE
                                                 : upwc_pkg::ST_L1_REQ;
      end
      upwc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = upwc_pkg::ST_IDLE;
        end
      end
      default: state_d = upwc_pkg::ST_IDLE;
    endcase
  end

  // outputs of each state: store access, reason, page bounds
  always_comb begin
    in_ready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_addr_o  = unit_idx[AddrW-1:0];
    ram_wdata_o = word_data_i;
    reason_d    = reason_q;
    va_pn_d     = va_pn_q;
    last_pn_d   = last_pn_q;
    unique case (state_q)
      upwc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_addr_o = widx_ext[AddrW-1:0];
        ram_we_o   = in_valid_i && (opcode_i == upwc_pkg::OP_TABLE_WRITE) &&
                     (widx_ext < StoreWordsW);
        reason_d   = upwc_pkg::RSN_OK;
      end
      upwc_pkg::ST_SETUP: begin
        va_pn_d   = addr_q[31:12];
        last_pn_d = end_sum[31:12] + upwc_pkg::PageW'(|end_sum[11:0]);
        if (end_wrap) begin
          reason_d = upwc_pkg::RSN_WRAP;
        end else if (end_over) begin
          reason_d = upwc_pkg::RSN_ABOVE_LIMIT;
        end
      end
      upwc_pkg::ST_L1_REQ: begin
        if (page_left && unit_outside) begin
          reason_d = upwc_pkg::RSN_OUTSIDE;
        end
      end
      upwc_pkg::ST_L1_CHK: begin
        if (!ram_rdata_i[upwc_pkg::PteBitV]) begin
          reason_d = upwc_pkg::RSN_L1_INVALID;
        end else if (unit_outside) begin
          reason_d = upwc_pkg::RSN_OUTSIDE;
        end
      end
      upwc_pkg::ST_L0_CHK: begin
        va_pn_d = va_pn_q + upwc_pkg::PageW'(1);
        if (!ram_rdata_i[upwc_pkg::PteBitV]) begin
          reason_d = upwc_pkg::RSN_L0_INVALID;
        end else if (!ram_rdata_i[upwc_pkg::PteBitU]) begin
          reason_d = upwc_pkg::RSN_NOT_USER;
        end else if (need_w_q && !ram_rdata_i[upwc_pkg::PteBitW]) begin
          reason_d = upwc_pkg::RSN_NOT_WRITABLE;
        end
      end
      upwc_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= upwc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == upwc_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    reason_q  <= reason_d;
    va_pn_q   <= va_pn_d;
    last_pn_q <= last_pn_d;
    if (state_q == upwc_pkg::ST_IDLE && in_valid_i) begin
      addr_q   <= buf_address_i;
      len_q    <= buf_length_i;
      need_w_q <= (opcode_i == upwc_pkg::OP_CHECK_WRITE);
    end
    if (state_q == upwc_pkg::ST_DONE && out_free) begin
      out_reason_q <= reason_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign access_ok_o = (out_reason_q == upwc_pkg::RSN_OK);
  assign reason_o    = out_reason_q;

endmodule

`default_nettype wire

// ===== hw/rtl/user_buffer_page_walk_check.sv =====
// ----------------------------------------------------------------------------
// user_buffer_page_walk_check: sv32 user buffer permission check
// table word writes and two-level page walks over a single port table store
// ----------------------------------------------------------------------------
// sequence: a table write or unused opcode goes from accept straight to the done state
// a check goes through setup, then walks each page in the level-1 request, level-1
//   check and level-0 check states (level-1 read, level-0 read, entry check); a wrap
//   or limit failure goes from setup to done, and a failing page ends the walk early
// throughput: one item at a time, the next item is taken once the result is
//   in the output register, while that result still waits to be taken
// reset: control and root ppn clear, the table store is not cleared
`default_nettype none

module user_buffer_page_walk_check #(
  parameter int unsigned STORE_WORDS = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [21:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [15:0] word_index_i,
  input  wire logic [31:0] word_data_i,
  input  wire logic [31:0] buf_address_i,
  input  wire logic [31:0] buf_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             access_ok_o,
  output logic [2:0]       reason_o
);

  localparam int unsigned AddrW = $clog2(STORE_WORDS);

  logic [upwc_pkg::PpnW-1:0] root_ppn_q;
  logic                      ram_we;
  logic [AddrW-1:0]          ram_addr;
  logic [31:0]               ram_wdata;
  logic [31:0]               ram_rdata;

  // root table register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ppn_q <= '0;
    end else if (cfg_we_i) begin
      root_ppn_q <= cfg_wdata_i;
    end
  end

  // page table store
  upwc_ram #(
    .Width(32),
    .Depth(STORE_WORDS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // walk sequencer
  upwc_walker #(
    .StoreWords(STORE_WORDS),
    .AddrW     (AddrW)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .root_ppn_i   (root_ppn_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .word_index_i (word_index_i),
    .word_data_i  (word_data_i),
    .buf_address_i(buf_address_i),
    .buf_length_i (buf_length_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .access_ok_o  (access_ok_o),
    .reason_o     (reason_o),
    .ram_we_o     (ram_we),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata),
    .ram_rdata_i  (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the user buffer page walk check
// builds sv32 page tables through table word writes, runs read and write
// buffer checks and compares every result with an in-bench page walk model,
// mostly under random idle cycles on both handshakes
// ----------------------------------------------------------------------------

module tb_top;
  import upwc_pkg::*;

  localparam int unsigned STORE_WORDS    = 65536;
  localparam int unsigned ITEM_TARGET    = 1950;
  localparam int unsigned CYCLE_LIMIT    = 2000000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MAX_WALK_PAGES = 40;
  localparam int unsigned IDLE_PERCENT   = 21;
  localparam int unsigned MAX_PRINTS     = 40;
  localparam logic [31:0] PAGE_MASK      = 32'h0000_0fff;
  localparam logic [31:0] PAGE_BYTES     = 32'h0000_1000;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  // one input item
  typedef struct {
    logic [1:0]  op;
    logic [15:0] word_index;
    logic [31:0] word_data;
    logic [31:0] address;
    logic [31:0] span;
  } walk_item_t;

  // one expected result
  typedef struct {
    logic    ok;
    reason_e reason;
  } verdict_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [21:0] cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic [1:0]  opcode_i     = '0;
  logic [15:0] word_index_i = '0;
  logic [31:0] word_data_i  = '0;
  logic [31:0] buf_address_i = '0;
  logic [31:0] buf_length_i = '0;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        access_ok_o;
  logic [2:0]  reason_o;

  // walk model state
  logic [31:0] table_copy [STORE_WORDS];
  bit          word_filled [STORE_WORDS];
  logic [21:0] root_ppn_q = '0;

  verdict_t    verdict_q[$];
  int unsigned items_sent  = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;

  // address windows mapped by the current random phase
  logic [9:0]  win_vpn1  [3];
  logic [9:0]  win_vpn0  [3];
  int unsigned win_pages [3];

  user_buffer_page_walk_check #(
    .STORE_WORDS(STORE_WORDS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .word_index_i (word_index_i),
    .word_data_i  (word_data_i),
    .buf_address_i(buf_address_i),
    .buf_length_i (buf_length_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .access_ok_o  (access_ok_o),
    .reason_o     (reason_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run time guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    // keep the log short, count them all
    if (mismatches < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // two-level walk over the modeled store, first failure wins
  // walk_safe drops walks that touch a never written word or run too long
  function automatic reason_e predict_walk(input logic [31:0] start, input logic [31:0] span,
                                           input bit for_write, output bit walk_safe);
    logic [31:0] stop;
    logic [31:0] va;
    logic [31:0] last;
    logic [31:0] pte1;
    logic [31:0] pte0;
    logic [40:0] idx1;
    logic [40:0] idx0;
    int unsigned pages;
    walk_safe = 1'b1;
    stop = start + span;
    if (stop < start) return RSN_WRAP;
    if (stop > UserLimit) return RSN_ABOVE_LIMIT;
    va = start & ~PAGE_MASK;
    last = (stop + PAGE_MASK) & ~PAGE_MASK;
    pages = 0;
    while (va < last) begin
      pages++;
      if (pages > MAX_WALK_PAGES) begin
        walk_safe = 1'b0;
        return RSN_OK;
      end
      // level-1 entry
      idx1 = {root_ppn_q, 10'd0} + va[31:22];
      if (idx1 >= STORE_WORDS) return RSN_OUTSIDE;
      if (!word_filled[idx1[15:0]]) begin
        walk_safe = 1'b0;
        return RSN_OK;
      end
      pte1 = table_copy[idx1[15:0]];
      if (!pte1[PteBitV]) return RSN_L1_INVALID;
      // level-0 entry, megapages are still treated as pointers
      idx0 = {pte1[31:10], 10'd0} + va[21:12];
      if (idx0 >= STORE_WORDS) return RSN_OUTSIDE;
      if (!word_filled[idx0[15:0]]) begin
        walk_safe = 1'b0;
        return RSN_OK;
      end
      pte0 = table_copy[idx0[15:0]];
      if (!pte0[PteBitV]) return RSN_L0_INVALID;
      if (!pte0[PteBitU]) return RSN_NOT_USER;
      if (for_write && !pte0[PteBitW]) return RSN_NOT_WRITABLE;
      va += PAGE_BYTES;
    end
    return RSN_OK;
  endfunction

  // present one item, hold it until taken, then queue its expected result
  task automatic send_item(input walk_item_t item);
    verdict_t want;
    reason_e  rsn;
    bit       safe;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= item.op;
    word_index_i  <= item.word_index;
    word_data_i   <= item.word_data;
    buf_address_i <= item.address;
    buf_length_i  <= item.span;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // accepted at this edge
    want.ok = 1'b1;
    want.reason = RSN_OK;
    case (item.op)
      OP_TABLE_WRITE: begin
        table_copy[item.word_index] = item.word_data;
        word_filled[item.word_index] = 1'b1;
      end
      OP_CHECK_READ, OP_CHECK_WRITE: begin
        rsn = predict_walk(item.address, item.span, item.op == OP_CHECK_WRITE, safe);
        want.reason = rsn;
        want.ok = (rsn == RSN_OK);
      end
      default: ;
    endcase
    verdict_q.push_back(want);
    items_sent++;
  endtask

  task automatic send_word(input logic [15:0] idx, input logic [31:0] data);
    walk_item_t item;
    item.op = OP_TABLE_WRITE;
    item.word_index = idx;
    item.word_data = data;
    item.address = $urandom;
    item.span = $urandom;
    send_item(item);
  endtask

  task automatic send_check(input logic [1:0] op, input logic [31:0] addr,
                            input logic [31:0] span);
    walk_item_t item;
    item.op = op;
    item.word_index = 16'($urandom);
    item.word_data = $urandom;
    item.address = addr;
    item.span = span;
    send_item(item);
  endtask

  task automatic send_unused();
    walk_item_t item;
    item.op = OP_UNUSED;
    item.word_index = 16'($urandom);
    item.word_data = $urandom;
    item.address = $urandom;
    item.span = $urandom;
    send_item(item);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_root_ppn(input logic [21:0] ppn);
    wait_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ppn;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    root_ppn_q = ppn;
  endtask

  // hand-built tables under root 0, at least one case per reason
  task automatic test_directed();
    write_root_ppn(22'd0);
    send_word(16'd0, 32'h0);
    send_check(OP_CHECK_READ, 32'h0, 32'h10);
    // level-0 table at page 1: full, read-only, kernel, invalid
    send_word(16'd0, {22'd1, 10'h001});
    send_word(16'd1024, 32'h17);
    send_word(16'd1025, 32'h13);
    send_word(16'd1026, 32'h07);
    send_word(16'd1027, 32'h0);
    send_check(OP_CHECK_WRITE, 32'h0, 32'h1000);
    send_check(OP_CHECK_WRITE, 32'h0, 32'h2000);
    send_check(OP_CHECK_READ, 32'h10, 32'h1ff0);
    send_check(OP_CHECK_READ, 32'h1ffc, 32'h8);
    // zero length, unaligned then aligned
    send_check(OP_CHECK_READ, 32'h3004, 32'h0);
    send_check(OP_CHECK_READ, 32'h3000, 32'h0);
    // level-0 table beyond the store
    send_word(16'd1, {22'd64, 10'h001});
    send_check(OP_CHECK_WRITE, 32'h0040_0000, 32'h1);
    // all-ones entry, buffer ending exactly at the user limit
    send_word(16'd511, 32'hffff_ffff);
    send_check(OP_CHECK_READ, 32'h7fff_f000, 32'h1000);
    // range checks ahead of any walk
    send_check(OP_CHECK_READ, 32'hffff_ffff, 32'h1);
    send_check(OP_CHECK_WRITE, 32'h7fff_ffff, 32'h2);
    send_check(OP_CHECK_READ, 32'h8000_0000, 32'h0);
    send_check(OP_CHECK_WRITE, 32'h0, 32'hffff_ffff);
    send_unused();
  endtask

  // root page at the top of the range and at the last store page
  task automatic test_root_extremes();
    write_root_ppn(22'h3f_ffff);
    send_check(OP_CHECK_READ, 32'h0, 32'h1);
    send_check(OP_CHECK_WRITE, 32'h7fff_f000, 32'h1000);
    send_check(OP_CHECK_READ, 32'h5000, 32'h0);
    send_check(OP_CHECK_WRITE, 32'hffff_ffff, 32'hffff_ffff);
    write_root_ppn(22'd63);
    send_word(16'hfc00, {22'd1, 10'h001});
    send_check(OP_CHECK_READ, 32'h0, 32'h1000);
    send_check(OP_CHECK_WRITE, 32'h0, 32'h3000);
  endtask

  // map three windows of consecutive pages with mostly usable entries
  task automatic build_windows();
    logic [21:0] l0_ppn;
    logic [31:0] pte;
    int unsigned kind;
    for (int w = 0; w < 3; w++) begin
      win_vpn1[w]  = 10'($urandom_range(511));
      win_pages[w] = $urandom_range(12, 4);
      win_vpn0[w]  = 10'($urandom_range(1024 - win_pages[w]));
      l0_ppn = 22'($urandom_range(63));
      kind = $urandom_range(9);
      pte = $urandom;
      if (kind < 8) pte = {l0_ppn, pte[9:1], 1'b1};
      else if (kind == 8) pte[PteBitV] = 1'b0;
      else pte = {22'($urandom_range(22'h3f_ffff, 64)), pte[9:1], 1'b1};
      if (root_ppn_q < 64) send_word(16'({root_ppn_q, 10'd0} + win_vpn1[w]), pte);
      for (int i = 0; i < win_pages[w]; i++) begin
        pte = $urandom;
        if ($urandom_range(9) < 7) begin
          pte[PteBitV] = 1'b1;
          pte[PteBitU] = 1'b1;
          pte[PteBitW] = 1'b1;
        end
        send_word(16'({l0_ppn, 10'd0} + win_vpn0[w] + i), pte);
      end
    end
  endtask

  // a check whose walk only reads written words within MAX_WALK_PAGES pages, else a wrapping buffer
  task automatic random_check();
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] span;
    int unsigned w;
    int unsigned pick;
    bit          safe;
    reason_e     rsn;
    op = $urandom_range(1) ? OP_CHECK_WRITE : OP_CHECK_READ;
    repeat (8) begin
      w = $urandom_range(2);
      addr = {win_vpn1[w], 10'(win_vpn0[w] + $urandom_range(win_pages[w] - 1)),
              12'($urandom)};
      pick = $urandom_range(99);
      if (pick < 55) begin
        span = $urandom_range(3 * 4096);
      end else if (pick < 65) begin
        addr[11:0] = 12'd0;
        span = 4096 * $urandom_range(3);
      end else if (pick < 72) begin
        span = 32'h0;
      end else if (pick < 87) begin
        addr = $urandom;
        span = $urandom;
      end else begin
        addr = $urandom;
        span = $urandom_range(8192);
      end
      rsn = predict_walk(addr, span, op == OP_CHECK_WRITE, safe);
      if (safe) begin
        send_check(op, addr, span);
        return;
      end
    end
    send_check(op, 32'h8000_0000 | $urandom, 32'h8000_0000 | $urandom);
  endtask

  // phases of fresh root, fresh windows and a mix of checks and noise
  task automatic test_random_walks();
    int unsigned phase;
    int unsigned pick;
    logic [21:0] root;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(9))
        0:       root = 22'($urandom_range(22'h3f_ffff, 64));
        1:       root = 22'd0;
        2:       root = 22'd63;
        default: root = 22'($urandom_range(63));
      endcase
      write_root_ppn(root);
      // a long stretch with no idle cycles on either side
      steady = (phase == 4 || phase == 5);
      build_windows();
      repeat (48) begin
        pick = $urandom_range(99);
        if (pick < 8) send_word(16'($urandom), $urandom);
        else if (pick < 12) send_unused();
        else random_check();
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // result check against the oldest expectation, ready toggles at random
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item ok=%0d reason=%0d",
                                  access_ok_o, reason_o));
      end else begin
        want = verdict_q.pop_front();
        if (access_ok_o !== want.ok)
          report_mismatch($sformatf("access_ok got %0d want %0d", access_ok_o, want.ok));
        if (reason_o !== want.reason)
          report_mismatch($sformatf("reason got %0d want %0d", reason_o, want.reason));
      end
    end
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // test sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_root_extremes();
    test_random_walks();
    wait_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
